FILE: src/ctrr_pkg.sv
// ----------------------------------------------------------------------------
// ctrr_pkg: shared types and constants for the clipped trapezoid row runs
// Word layouts, configuration register indexes, controller states and the
// command / status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ctrr_pkg;

  // Field widths
  localparam int ROW_W     = 6;
  localparam int ROWIN_W   = 15;
  localparam int COL_W     = 15;
  localparam int X_W       = 32;
  localparam int LEN_W     = 16;
  localparam int COLOR_W   = 16;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;

  // Slope divider: one quotient bit per cycle
  localparam int DIV_STEPS = X_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_LEFT   = 2'd0,
    CFG_CLIP_RIGHT  = 2'd1,
    CFG_CLIP_TOP    = 2'd2,
    CFG_CLIP_BOTTOM = 2'd3
  } cfg_index_t;

  // Input word: one trapezoid
  typedef struct packed {
    logic [ROWIN_W-1:0]    top_row;
    logic signed [X_W-1:0] top_left_x;
    logic signed [X_W-1:0] top_right_x;
    logic [ROWIN_W-1:0]    bottom_row;
    logic signed [X_W-1:0] bottom_left_x;
    logic signed [X_W-1:0] bottom_right_x;
    logic [COLOR_W-1:0]    fill_color;
  } trap_t;

  // Output word: one row run
  typedef struct packed {
    logic [ROW_W-1:0]   run_row;
    logic [COL_W-1:0]   run_start;
    logic [LEN_W-1:0]   run_length;
    logic               run_present;
    logic [COLOR_W-1:0] run_color;
    logic               last_run;
  } run_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_MUL,
    ST_ADV,
    ST_ROW
  } state_t;

  typedef struct packed {
    logic load;        // capture an accepted trapezoid
    logic div_start;   // start both slope divisions
    logic slope_load;  // take quotients, seed the edges
    logic mul;         // clip-advance products, clipped row range
    logic adv;         // add the advance, set the row counters
    logic emit;        // produce one row run, step the edges
  } cmd_t;

  typedef struct packed {
    logic bad_order;   // bottom row above top row
    logic div_done;
    logic no_rows;     // nothing left after clipping
    logic last_row;
    logic out_free;    // output register can take a word
  } sts_t;

endpackage

FILE: src/ctrr_stream_if.sv
// ----------------------------------------------------------------------------
// ctrr_stream_if: valid/ready channel carrying one word of a given type
// A word moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface ctrr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/ctrr_div.sv
// ----------------------------------------------------------------------------
// ctrr_div: signed by unsigned restoring divider, truncating toward zero
// Divides a 32-bit two's complement value by a 15-bit height, one quotient
// bit per cycle. A zero divisor yields a zero quotient.
// ----------------------------------------------------------------------------
module ctrr_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ctrr_pkg::X_W-1:0]     num,
  input  logic [ctrr_pkg::ROWIN_W-1:0] den,
  output logic                         busy,
  output logic [ctrr_pkg::X_W-1:0]     quot
);
  import ctrr_pkg::*;

  logic [X_W-1:0]       work;
  logic [ROWIN_W-1:0]   rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 neg;
  logic [ROWIN_W:0]     rem_sh;
  logic                 fits;
  logic [ROWIN_W-1:0]   rem_next;

  // One restoring step
  always_comb begin
    rem_sh   = {rem, work[X_W-1]};
    fits     = rem_sh >= {1'b0, den};
    rem_next = fits ? ROWIN_W'(rem_sh - {1'b0, den}) : ROWIN_W'(rem_sh);
  end

  // Control: busy from start until all DIV_STEPS restoring steps are done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Magnitude shifts out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      work <= num[X_W-1] ? X_W'(-num) : num;
      neg  <= num[X_W-1];
      rem  <= '0;
    end else if (busy) begin
      work <= {work[X_W-2:0], fits};
      rem  <= rem_next;
    end
  end

  assign quot = (den == '0) ? '0 : (neg ? X_W'(-work) : work);

endmodule

FILE: src/ctrr_ctrl.sv
// ----------------------------------------------------------------------------
// ctrr_ctrl: sequencer for one trapezoid
// Accept, check the row order, start the slope divisions, clip-advance the
// edges, then one row run per clipped row while the output register has room.
// ----------------------------------------------------------------------------
module ctrr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ctrr_pkg::sts_t sts,
  output ctrr_pkg::cmd_t cmd
);
  import ctrr_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (sts.bad_order) begin
          state_next = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.slope_load = 1'b1;
          state_next     = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADV;
      end
      ST_ADV: begin
        cmd.adv    = 1'b1;
        state_next = sts.no_rows ? ST_IDLE : ST_ROW;
      end
      ST_ROW: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_row) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/ctrr_dpath.sv
// ----------------------------------------------------------------------------
// ctrr_dpath: edge, slope and clip datapath with the output register
// Holds the clip window, captured trapezoid, left and right edge accumulators
// with their slopes, the row counters and the registered output word.
// ----------------------------------------------------------------------------
module ctrr_dpath #(
  parameter int DISPLAY_ROWS = 64,
  parameter int PIXEL_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ctrr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctrr_pkg::CFG_W-1:0]     cfg_data,
  input  ctrr_pkg::trap_t                trap_data,
  input  ctrr_pkg::cmd_t                 cmd,
  output ctrr_pkg::sts_t                 sts,
  output logic                           run_valid,
  input  logic                           run_ready,
  output ctrr_pkg::run_t                 run_data
);
  import ctrr_pkg::*;

  localparam logic [ROW_W-1:0]   LAST_ROW   = ROW_W'(DISPLAY_ROWS - 1);
  localparam logic [COLOR_W-1:0] COLOR_MASK = COLOR_W'((33'd1 << PIXEL_BITS) - 33'd1);

  // Clip window
  logic [COL_W-1:0] clip_left;
  logic [COL_W-1:0] clip_right;
  logic [ROW_W-1:0] clip_top;
  logic [ROW_W-1:0] clip_bottom;

  // Captured trapezoid
  logic [ROWIN_W-1:0] topy;
  logic [ROWIN_W-1:0] boty;
  logic [X_W-1:0]     tlx;
  logic [X_W-1:0]     trx;
  logic [X_W-1:0]     diff_l;
  logic [X_W-1:0]     diff_r;
  logic [COLOR_W-1:0] color;

  // Edge walk
  logic [X_W-1:0]     left_edge;
  logic [X_W-1:0]     right_edge;
  logic [X_W-1:0]     left_slope;
  logic [X_W-1:0]     right_slope;
  logic [X_W-1:0]     prod_l;
  logic [X_W-1:0]     prod_r;
  logic [ROWIN_W-1:0] top_c;
  logic [ROW_W-1:0]   bot_c;
  logic [ROW_W-1:0]   current_row;
  logic [ROW_W-1:0]   final_row;

  // Divider hookup
  logic [ROWIN_W-1:0] dy;
  logic               busy_l;
  logic               busy_r;
  logic [X_W-1:0]     quot_l;
  logic [X_W-1:0]     quot_r;

  // Clip setup terms
  logic               above_clip;
  logic [ROW_W-1:0]   adv_d;
  logic [ROW_W-1:0]   bot_lim;

  // Row terms
  logic               swap;
  logic [X_W-1:0]     le_eff;
  logic [X_W-1:0]     re_eff;
  logic [X_W-1:0]     ls_eff;
  logic [X_W-1:0]     rs_eff;
  logic signed [15:0] floor_l;
  logic signed [15:0] floor_r;
  logic signed [16:0] ix1;
  logic signed [16:0] ix2;
  logic               present;
  logic [16:0]        span;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= COL_W'(0);
      clip_right  <= COL_W'(127);
      clip_top    <= ROW_W'(0);
      clip_bottom <= ROW_W'(63);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CLIP_LEFT:   clip_left   <= cfg_data;
        CFG_CLIP_RIGHT:  clip_right  <= cfg_data;
        CFG_CLIP_TOP:    clip_top    <= cfg_data[ROW_W-1:0];
        CFG_CLIP_BOTTOM: clip_bottom <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Slope dividers, both lanes in lockstep
  assign dy = boty - topy;

  ctrr_div u_div_l (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (diff_l),
    .den   (dy),
    .busy  (busy_l),
    .quot  (quot_l)
  );

  ctrr_div u_div_r (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (diff_r),
    .den   (dy),
    .busy  (busy_r),
    .quot  (quot_r)
  );

  // Vertical clip terms
  always_comb begin
    above_clip = topy < {{(ROWIN_W-ROW_W){1'b0}}, clip_top};
    adv_d      = above_clip ? ROW_W'(clip_top - topy[ROW_W-1:0]) : '0;
    bot_lim    = (clip_bottom < LAST_ROW) ? clip_bottom : LAST_ROW;
  end

  // Row run: swap crossed edges, floor, clamp horizontally
  always_comb begin
    swap    = $signed(left_edge) > $signed(right_edge);
    le_eff  = swap ? right_edge  : left_edge;
    re_eff  = swap ? left_edge   : right_edge;
    ls_eff  = swap ? right_slope : left_slope;
    rs_eff  = swap ? left_slope  : right_slope;
    floor_l = $signed(le_eff[X_W-1:16]);
    floor_r = $signed(re_eff[X_W-1:16]);
    ix1     = (17'(floor_l) < $signed({2'b00, clip_left}))  ? $signed({2'b00, clip_left})
                                                            : 17'(floor_l);
    ix2     = (17'(floor_r) > $signed({2'b00, clip_right})) ? $signed({2'b00, clip_right})
                                                            : 17'(floor_r);
    present = ix1 <= ix2;
    span    = 17'(ix2 - ix1 + 17'sd1);
  end

  // Trapezoid, slopes, edges and rows
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      topy   <= trap_data.top_row;
      boty   <= trap_data.bottom_row;
      tlx    <= trap_data.top_left_x;
      trx    <= trap_data.top_right_x;
      diff_l <= trap_data.bottom_left_x  - trap_data.top_left_x;
      diff_r <= trap_data.bottom_right_x - trap_data.top_right_x;
      color  <= trap_data.fill_color & COLOR_MASK;
    end
    if (cmd.slope_load) begin
      left_slope  <= quot_l;
      right_slope <= quot_r;
      left_edge   <= tlx;
      right_edge  <= trx;
    end
    if (cmd.mul) begin
      prod_l <= X_W'(X_W'(adv_d) * left_slope);
      prod_r <= X_W'(X_W'(adv_d) * right_slope);
      top_c  <= above_clip ? {{(ROWIN_W-ROW_W){1'b0}}, clip_top} : topy;
      bot_c  <= (boty < {{(ROWIN_W-ROW_W){1'b0}}, bot_lim}) ? boty[ROW_W-1:0] : bot_lim;
    end
    if (cmd.adv) begin
      left_edge   <= left_edge + prod_l;
      right_edge  <= right_edge + prod_r;
      current_row <= top_c[ROW_W-1:0];
      final_row   <= bot_c;
    end
    if (cmd.emit) begin
      left_edge   <= le_eff + ls_eff;
      right_edge  <= re_eff + rs_eff;
      left_slope  <= ls_eff;
      right_slope <= rs_eff;
      current_row <= current_row + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
    end else if (cmd.emit) begin
      run_valid <= 1'b1;
    end else if (run_ready) begin
      run_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      run_data.run_row     <= current_row;
      run_data.run_start   <= present ? ix1[COL_W-1:0] : '0;
      run_data.run_length  <= present ? span[LEN_W-1:0] : '0;
      run_data.run_present <= present;
      run_data.run_color   <= color;
      run_data.last_run    <= current_row == final_row;
    end
  end

  // Status to the controller
  always_comb begin
    sts.bad_order = boty < topy;
    sts.div_done  = !busy_l && !busy_r;
    sts.no_rows   = top_c > {{(ROWIN_W-ROW_W){1'b0}}, bot_c};
    sts.last_row  = current_row == final_row;
    sts.out_free  = !run_valid || run_ready;
  end

endmodule

FILE: src/clipped_trapezoid_row_runs_top.sv
// ----------------------------------------------------------------------------
// clipped_trapezoid_row_runs_top: scanline trapezoid fill into row runs
// Takes one trapezoid word on trap and writes one run word per clipped row
// on run, top row first, with last_run set on the final row.
//
// Channels: trap (sink) and run (source) are valid/ready; a word moves when
// both are high. The clip window is written through cfg_we / cfg_index /
// cfg_data; the user must do so only while no trapezoid is in progress,
// as the block itself does not enforce this.
// Sequence: after a trapezoid is taken, setup, then the two slope divisions
// (both run side by side, one quotient bit per cycle), then the clip
// advance; run words follow, one run per cycle while run is ready. A
// trapezoid with bottom above top ends after setup, one fully clipped away
// after the clip advance, neither producing a run word.
// trap is ready only between trapezoids, while the last run word may still
// sit in the output register waiting to be taken.
// Stall: a low run.ready holds the output word and pauses the row walk.
// Reset: clip window returns to columns 0..127, rows 0..63; no word pending.
// ----------------------------------------------------------------------------
module clipped_trapezoid_row_runs_top #(
  parameter int DISPLAY_ROWS = 64,
  parameter int PIXEL_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ctrr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctrr_pkg::CFG_W-1:0]     cfg_data,
  ctrr_stream_if.sink                    trap,
  ctrr_stream_if.source                  run
);
  import ctrr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  ctrr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (trap.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ctrr_dpath #(
    .DISPLAY_ROWS (DISPLAY_ROWS),
    .PIXEL_BITS   (PIXEL_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .trap_data (trap.data),
    .cmd       (cmd),
    .sts       (sts),
    .run_valid (run.valid),
    .run_ready (run.ready),
    .run_data  (run.data)
  );

  assign trap.ready = in_ready;

  // A run word is only produced into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!run.valid || run.ready))
    else $error("run word produced over a pending word");

  // Taking a trapezoid closes the input until it is finished
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (trap.valid && trap.ready) |=> !trap.ready)
    else $error("input still open after accepting a trapezoid");

  // The final row run returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.last_row) |=> (trap.ready && run.valid && run.data.last_run))
    else $error("final run did not end the trapezoid");

  // An empty row carries no pixels
  a_empty_row: assert property (@(posedge clk) disable iff (rst)
    (run.valid && !run.data.run_present) |->
      (run.data.run_length == '0 && run.data.run_start == '0))
    else $error("empty row with nonzero run");

endmodule
